// ----- rtl/core/lts_pkg.sv -----
// Package for the line table substring search block.
// Holds widths, character codes, register indexes, payload structs and the fold function.
// No dependencies.
package lts_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int LINE_MAX_DEF    = 512;
    localparam int FILTER_CHARS    = 32;
    localparam int CHAR_REGS       = 4;
    localparam int LEN_W           = 6;
    localparam int LIMIT_W         = 10;
    localparam int INDEX_W         = 9;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int QUEUE_DEPTH     = 4;
    localparam logic [LIMIT_W-1:0] REPORT_LIMIT_RST = 10'd512;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_US    = 8'h5F;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE,
        CFG_FILTER_LENGTH,
        CFG_REPORT_LIMIT,
        CFG_CHARS_A,
        CFG_CHARS_B,
        CFG_CHARS_C,
        CFG_CHARS_D
    } t_cfg_index;

    typedef enum logic {
        KIND_INDEX,
        KIND_SUMMARY
    } t_kind;

    typedef struct packed {
        logic [7:0] table_byte;
        logic       end_of_table;
    } t_item;

    typedef struct packed {
        t_kind              result_kind;
        logic [INDEX_W-1:0] line_index;
        logic [LIMIT_W-1:0] line_count;
        logic [LIMIT_W-1:0] total_matches;
        logic [LIMIT_W-1:0] reported_count;
        logic               last_of_run;
    } t_result;

    typedef struct packed {
        logic             step;
        logic             start;
        logic [7:0]       c;
        logic [7:0]       fc;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] elen;
    } t_cell_ctl;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CH_US || c == CH_SLASH) begin
            r = CH_SPACE;
        end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/lts_cell.sv -----
// One filter position of the shift-and chain: holds one prefix match bit.
// Also compares its raw character for the exact whole-line check. Uses lts_pkg.
module lts_cell
    import lts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [LEN_W-1:0] i_idx,
    input  logic [7:0]       i_fchar,
    input  logic             i_prev,
    output logic             o_bit,
    output logic             o_tap,
    output logic             o_xeq
);

    logic r_bit;
    logic n_bit;
    logic w_base;
    logic w_eq;

    always_comb begin
        w_base = (i_idx == '0) ? 1'b1 : (i_prev & ~i_ctl.start);
        w_eq   = (i_idx < i_ctl.len) && (i_fchar != 8'h00) && (fold(i_fchar) == i_ctl.fc);
        n_bit  = w_base & w_eq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_ctl.step) begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;
    assign o_tap = n_bit && ((i_idx + LEN_W'(1)) == i_ctl.len);
    assign o_xeq = (i_idx == i_ctl.elen) && (i_fchar == i_ctl.c);

endmodule

// ----- rtl/core/lts_out_queue.sv -----
// Result queue: takes up to two results per transfer, gives one per cycle while i_ready is high.
// Uses lts_pkg.
module lts_out_queue
    import lts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push0,
    input  t_result i_data0,
    input  logic    i_push1,
    input  t_result i_data1,
    output logic    o_space2,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_result      r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic [PW-1:0] w_wp1;
    logic          w_pop;

    assign w_wp1    = r_wp + PW'(1);
    assign w_pop    = o_valid && i_ready;
    assign o_valid  = (r_cnt != '0);
    assign o_data   = r_mem[r_rp];
    assign o_space2 = (r_cnt <= (PW+1)'(QUEUE_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wp] <= i_data0;
        end
        if (i_push1) begin
            r_mem[w_wp1] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PW'(i_push0) + PW'(i_push1);
            r_rp  <= r_rp + PW'(w_pop);
            r_cnt <= r_cnt + (PW+1)'(i_push0) + (PW+1)'(i_push1) - (PW+1)'(w_pop);
        end
    end

endmodule

// ----- rtl/core/line_table_substring_search.sv -----
// Top level of the line table substring search: line tracking, counters, config registers.
// Instantiates the lts_cell chain and lts_out_queue. Uses lts_pkg.
//
//  channel   direction  handshake              payload
//  item      in         i_valid / o_ready      i_item   (t_item)
//  result    out        o_valid / i_ready      o_result (t_result)
//  config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// One table byte per cycle while o_ready is high; each transfer updates the cell chain in that cycle.
// A byte yields zero, one or two results; the four-entry queue drains one per cycle while i_ready is high,
// so o_ready drops while fewer than two entries are free.
// o_ready is low in the cycle after each config write (effective length update).
// Synchronous active-low reset; no clearing pass.
module line_table_substring_search
    import lts_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int LINE_MAX    = LINE_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_item                 i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW   = $clog2(LINE_MAX + 1);
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

    // configuration
    logic                  r_mode;
    logic [LEN_W-1:0]      r_filter_length;
    logic [LIMIT_W-1:0]    r_report_limit;
    logic [CFG_DATA_W-1:0] r_chars [CHAR_REGS];
    logic [LEN_W-1:0]      r_eff_len, n_eff_len;
    logic                  r_cfg_busy;

    // pass state
    logic          r_line_hit, r_line_open, r_exact_equal;
    logic [LEN_W-1:0] r_exact_length;
    logic [CW-1:0] r_lines_seen, r_matches_seen, r_matches_reported;

    logic          n_line_hit, n_exact_equal;
    logic [LEN_W-1:0] n_exact_length;
    logic [CW-1:0] n_lines_seen, n_matches_seen, n_matches_reported;

    logic [7:0]           w_fchar [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_bit, w_tap, w_xeq;
    t_cell_ctl            w_ctl;

    logic    w_acc, w_opening, w_open_now, w_is_nl, w_content, w_close, w_hit, w_emit;
    logic    w_ee_base;
    logic [LEN_W-1:0] w_el_base;
    logic    w_space2;
    t_result w_index_res, w_sum_res;

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_fchar
        if (k < FILTER_CHARS) begin : g_reg
            assign w_fchar[k] = r_chars[k / 8][(k % 8) * 8 +: 8];
        end else begin : g_zero
            assign w_fchar[k] = 8'h00;
        end
    end

    always_comb begin
        logic [LEN_W-1:0] lim;
        logic             found;
        lim   = (r_filter_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : r_filter_length;
        found = 1'b0;
        n_eff_len = lim;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (!found && (LEN_W'(k) < lim) && (w_fchar[k] == 8'h00)) begin
                n_eff_len = LEN_W'(k);
                found     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= 1'b0;
            r_filter_length <= '0;
            r_report_limit  <= REPORT_LIMIT_RST;
            for (int j = 0; j < CHAR_REGS; j++) begin
                r_chars[j] <= '0;
            end
            r_eff_len       <= '0;
            r_cfg_busy      <= 1'b0;
        end else begin
            r_eff_len  <= n_eff_len;
            r_cfg_busy <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_MODE:          r_mode          <= i_cfg_data[0];
                    CFG_FILTER_LENGTH: r_filter_length <= i_cfg_data[LEN_W-1:0];
                    CFG_REPORT_LIMIT:  r_report_limit  <= i_cfg_data[LIMIT_W-1:0];
                    CFG_CHARS_A:       r_chars[0]      <= i_cfg_data;
                    CFG_CHARS_B:       r_chars[1]      <= i_cfg_data;
                    CFG_CHARS_C:       r_chars[2]      <= i_cfg_data;
                    CFG_CHARS_D:       r_chars[3]      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_ready = w_space2 && !r_cfg_busy;
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        w_opening  = !r_line_open && (r_lines_seen < CW'(LINE_MAX));
        w_open_now = r_line_open || w_opening;
        w_is_nl    = (i_item.table_byte == CH_NL);
        w_content  = w_open_now && !w_is_nl;
        w_close    = w_open_now && (w_is_nl || i_item.end_of_table);

        w_ee_base  = w_opening ? 1'b1 : r_exact_equal;
        w_el_base  = w_opening ? '0 : r_exact_length;

        w_ctl.step  = w_acc && w_content;
        w_ctl.start = w_opening;
        w_ctl.c     = i_item.table_byte;
        w_ctl.fc    = fold(i_item.table_byte);
        w_ctl.len   = r_eff_len;
        w_ctl.elen  = w_el_base;

        n_line_hit     = (w_opening ? 1'b0 : r_line_hit) | (w_content && (|w_tap));
        n_exact_equal  = w_ee_base;
        n_exact_length = w_el_base;
        if (w_content) begin
            if ((w_el_base >= r_eff_len) || !(|w_xeq)) begin
                n_exact_equal = 1'b0;
            end
            if (w_el_base != '1) begin
                n_exact_length = w_el_base + LEN_W'(1);
            end
        end

        n_lines_seen = r_lines_seen + CW'(w_opening);

        if (r_mode) begin
            w_hit = (r_eff_len != '0) && n_exact_equal && (n_exact_length == r_eff_len);
        end else begin
            w_hit = (r_eff_len == '0) || n_line_hit;
        end

        w_emit = w_close && w_hit
              && (CMPW'(r_matches_reported) < CMPW'(r_report_limit))
              && (!r_mode || (r_matches_seen == '0));

        n_matches_seen     = r_matches_seen + CW'(w_close && w_hit);
        n_matches_reported = r_matches_reported + CW'(w_emit);

        w_index_res.result_kind    = KIND_INDEX;
        w_index_res.line_index     = INDEX_W'(n_lines_seen - CW'(1));
        w_index_res.line_count     = '0;
        w_index_res.total_matches  = '0;
        w_index_res.reported_count = '0;
        w_index_res.last_of_run    = !i_item.end_of_table;

        w_sum_res.result_kind    = KIND_SUMMARY;
        w_sum_res.line_index     = '0;
        w_sum_res.line_count     = LIMIT_W'(n_lines_seen);
        w_sum_res.total_matches  = LIMIT_W'(n_matches_seen);
        w_sum_res.reported_count = LIMIT_W'(n_matches_reported);
        w_sum_res.last_of_run    = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_hit         <= 1'b0;
            r_line_open        <= 1'b0;
            r_exact_equal      <= 1'b1;
            r_exact_length     <= '0;
            r_lines_seen       <= '0;
            r_matches_seen     <= '0;
            r_matches_reported <= '0;
        end else if (w_acc) begin
            if (i_item.end_of_table) begin
                r_line_hit         <= 1'b0;
                r_line_open        <= 1'b0;
                r_exact_equal      <= 1'b1;
                r_exact_length     <= '0;
                r_lines_seen       <= '0;
                r_matches_seen     <= '0;
                r_matches_reported <= '0;
            end else begin
                r_line_hit         <= n_line_hit;
                r_line_open        <= w_open_now && !w_close;
                r_exact_equal      <= n_exact_equal;
                r_exact_length     <= n_exact_length;
                r_lines_seen       <= n_lines_seen;
                r_matches_seen     <= n_matches_seen;
                r_matches_reported <= n_matches_reported;
            end
        end
    end

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        logic w_prev;
        if (k == 0) begin : g_first
            assign w_prev = 1'b1;
        end else begin : g_rest
            assign w_prev = w_bit[k-1];
        end
        lts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_idx   (LEN_W'(k)),
            .i_fchar (w_fchar[k]),
            .i_prev  (w_prev),
            .o_bit   (w_bit[k]),
            .o_tap   (w_tap[k]),
            .o_xeq   (w_xeq[k])
        );
    end

    lts_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push0  (w_acc && (w_emit || i_item.end_of_table)),
        .i_data0  (w_emit ? w_index_res : w_sum_res),
        .i_push1  (w_acc && w_emit && i_item.end_of_table),
        .i_data1  (w_sum_res),
        .o_space2 (w_space2),
        .o_valid  (o_valid),
        .o_data   (o_result),
        .i_ready  (i_ready)
    );

endmodule

// ----- rtl/core/lts_checker.sv -----
// Port-level checks for line_table_substring_search, attached by bind.
// Uses lts_pkg.
module lts_checker
    import lts_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input t_item                 i_item,
    input logic                  o_valid,
    input logic                  i_ready,
    input t_result               o_result,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("result dropped or changed while stalled");

    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_ready)
        else $error("item taken in the cycle after a config write");

    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.result_kind == KIND_SUMMARY) |-> o_result.last_of_run)
        else $error("summary not marked last");

    a_idx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.result_kind == KIND_INDEX)
        |-> (o_result.line_count == '0) && (o_result.total_matches == '0)
            && (o_result.reported_count == '0))
        else $error("index result carries summary fields");

    a_sum_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.result_kind == KIND_SUMMARY)
        |-> (o_result.reported_count <= o_result.total_matches)
            && (o_result.total_matches <= o_result.line_count))
        else $error("summary counts inconsistent");

endmodule

bind line_table_substring_search lts_checker u_lts_checker (.*);

// ----- tb/line_table_substring_search_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for line_table_substring_search: directed and random table passes,
// every index and summary transfer compared with an in-bench prediction of the search.
// Depends on lts_pkg and the RTL of line_table_substring_search.
module line_table_substring_search_tb;
    import lts_pkg::*;

    localparam int          RANDOM_ITEMS = 700;
    localparam int          SETTLE       = 8;
    localparam int          CYCLE_LIMIT  = 1_200_000;
    localparam int          SHOW_MAX     = 30;
    localparam int          TEXT_W       = 8 * FILTER_CHARS;
    localparam logic        MODE_FOLDED  = 1'b0;
    localparam logic        MODE_EXACT   = 1'b1;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    t_item                 i_item      = '0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    t_result               o_result;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // register shadow
    logic               sh_mode;
    logic [LEN_W-1:0]   sh_flen;
    logic [LIMIT_W-1:0] sh_limit;
    logic [TEXT_W-1:0]  sh_text;

    // pass state of the search
    logic [PATTERN_MAX_DEF-1:0] pr_hits;
    bit                         pr_hit;
    bit                         pr_open;
    bit                         pr_same;
    int unsigned                pr_run;
    int unsigned                pr_lines;
    int unsigned                pr_matches;
    int unsigned                pr_shown;

    t_result     pending_results[$];
    t_result     step_out[$];
    logic [7:0]  table_bytes[$];
    bit          calm        = 1'b0;
    int unsigned fail_count  = 0;
    int unsigned items_sent  = 0;
    int unsigned results_seen = 0;
    int unsigned passes_done = 0;
    int unsigned exact_passes = 0;
    int unsigned cycles      = 0;
    int unsigned stall_left  = 0;

    line_table_substring_search u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timed out, %0d results outstanding", $time, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [7:0] filter_at(int unsigned k);
        if (k >= FILTER_CHARS) begin
            return 8'h00;
        end
        return sh_text[8*k +: 8];
    endfunction

    function automatic logic [7:0] fold_char(logic [7:0] c);
        if (c == CH_US || c == CH_SLASH) begin
            return CH_SPACE;
        end
        if (c >= CH_UC_A && c <= CH_UC_Z) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic int unsigned filter_span();
        int unsigned lim;
        int unsigned k;
        lim = (sh_flen > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : sh_flen;
        for (k = 0; k < lim; k++) begin
            if (filter_at(k) == 8'h00) begin
                return k;
            end
        end
        return lim;
    endfunction

    function automatic void open_line();
        pr_hits = '0;
        pr_hit  = 1'b0;
        pr_same = 1'b1;
        pr_run  = 0;
        pr_open = 1'b1;
        pr_lines++;
    endfunction

    function automatic void clear_pass();
        pr_hits    = '0;
        pr_hit     = 1'b0;
        pr_same    = 1'b1;
        pr_run     = 0;
        pr_open    = 1'b0;
        pr_lines   = 0;
        pr_matches = 0;
        pr_shown   = 0;
    endfunction

    function automatic void take_char(logic [7:0] c, int unsigned span);
        logic [PATTERN_MAX_DEF-1:0] eq;
        int unsigned                k;
        eq = '0;
        for (k = 0; k < span; k++) begin
            if (filter_at(k) != 8'h00 && fold_char(filter_at(k)) == fold_char(c)) begin
                eq[k] = 1'b1;
            end
        end
        pr_hits = ((pr_hits << 1) | 1) & eq;
        if (span > 0 && pr_hits[span-1]) begin
            pr_hit = 1'b1;
        end
        if (pr_run >= span || filter_at(pr_run) != c) begin
            pr_same = 1'b0;
        end
        if (pr_run < 63) begin
            pr_run++;
        end
    endfunction

    function automatic void close_line(int unsigned span);
        bit      hit;
        bit      first;
        t_result r;
        if (sh_mode == MODE_FOLDED) begin
            hit = (span == 0) || pr_hit;
        end else begin
            hit = (span > 0) && pr_same && (pr_run == span);
        end
        pr_open = 1'b0;
        if (hit) begin
            first = (pr_matches == 0);
            pr_matches++;
            if (pr_shown < sh_limit && (sh_mode == MODE_FOLDED || first)) begin
                pr_shown++;
                r = '0;
                r.result_kind = KIND_INDEX;
                r.line_index  = INDEX_W'(pr_lines - 1);
                step_out.push_back(r);
            end
        end
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic eot);
        int unsigned span;
        t_result     r;
        span = filter_span();
        step_out.delete();
        if (!pr_open && pr_lines < LINE_MAX_DEF) begin
            open_line();
        end
        if (pr_open) begin
            if (b == CH_NL) begin
                close_line(span);
            end else begin
                take_char(b, span);
            end
        end
        if (eot) begin
            if (pr_open) begin
                close_line(span);
            end
            r = '0;
            r.result_kind    = KIND_SUMMARY;
            r.line_count     = LIMIT_W'(pr_lines);
            r.total_matches  = LIMIT_W'(pr_matches);
            r.reported_count = LIMIT_W'(pr_shown);
            step_out.push_back(r);
            clear_pass();
        end
        if (step_out.size() > 0) begin
            r = step_out.pop_back();
            r.last_of_run = 1'b1;
            step_out.push_back(r);
        end
        while (step_out.size() > 0) begin
            pending_results.push_back(step_out.pop_front());
        end
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string name, input logic [LIMIT_W-1:0] want,
                               input logic [LIMIT_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= SHOW_MAX) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= SHOW_MAX) begin
                $display("%0t: expected no result, got kind %0d index %0d", $time,
                         got.result_kind, got.line_index);
            end
            return;
        end
        want = pending_results.pop_front();
        results_seen++;
        check_field("result_kind", want.result_kind, got.result_kind);
        check_field("line_index", want.line_index, got.line_index);
        check_field("line_count", want.line_count, got.line_count);
        check_field("total_matches", want.total_matches, got.total_matches);
        check_field("reported_count", want.reported_count, got.reported_count);
        check_field("last_of_run", want.last_of_run, got.last_of_run);
    endtask

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        if (roll < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            check_result(o_result);
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_ready <= 1'b0;
        end else begin
            stall_left = calm ? 0 : pick_gap();
            i_ready <= (stall_left == 0);
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
            end
        end
    end

    // ---------------------------------------------------------------- driving

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int unsigned gap;
        t_item       it;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.table_byte   = b;
        it.end_of_table = eot;
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predict_byte(b, eot);
        items_sent++;
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic settle_idle();
        wait_results();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_config(input logic mode, input logic [LEN_W-1:0] flen,
                               input logic [LIMIT_W-1:0] limit, input logic [TEXT_W-1:0] text);
        int unsigned r;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MODE;
        i_cfg_data  <= CFG_DATA_W'(mode);
        @(posedge i_clk);
        i_cfg_index <= CFG_FILTER_LENGTH;
        i_cfg_data  <= CFG_DATA_W'(flen);
        @(posedge i_clk);
        i_cfg_index <= CFG_REPORT_LIMIT;
        i_cfg_data  <= CFG_DATA_W'(limit);
        @(posedge i_clk);
        for (r = 0; r < CHAR_REGS; r++) begin
            i_cfg_index <= CFG_IDX_W'(CFG_CHARS_A + r);
            i_cfg_data  <= text[CFG_DATA_W*r +: CFG_DATA_W];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        sh_mode  = mode;
        sh_flen  = flen;
        sh_limit = limit;
        sh_text  = text;
        if (mode == MODE_EXACT) begin
            exact_passes++;
        end
    endtask

    function automatic logic [TEXT_W-1:0] text_of(string s);
        logic [TEXT_W-1:0] t;
        int unsigned       k;
        t = '0;
        for (k = 0; k < s.len() && k < FILTER_CHARS; k++) begin
            t[8*k +: 8] = s[k];
        end
        return t;
    endfunction

    function automatic void add_text(string s);
        int unsigned k;
        for (k = 0; k < s.len(); k++) begin
            table_bytes.push_back(s[k]);
        end
    endfunction

    function automatic logic [7:0] letter();
        string pool;
        pool = "abcxyzABCXYZ_/ 09";
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    // random case for letters, any separator for a separator
    function automatic logic [7:0] respell(logic [7:0] c);
        int unsigned pick;
        if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z") begin
            return $urandom_range(0, 1) ? (c ^ 8'h20) : c;
        end
        if (c == CH_US || c == CH_SLASH || c == CH_SPACE) begin
            pick = $urandom_range(0, 2);
            return (pick == 0) ? CH_US : (pick == 1) ? CH_SLASH : CH_SPACE;
        end
        return c;
    endfunction

    task automatic send_table();
        int unsigned k;
        for (k = 0; k < table_bytes.size(); k++) begin
            if (k > 0 && !calm && $urandom_range(0, 39) == 0) begin
                wait_results();
            end
            send_byte(table_bytes[k], k == table_bytes.size() - 1);
        end
        table_bytes.delete();
        passes_done++;
        settle_idle();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_defaults();
        table_bytes.push_back(8'h00);
        table_bytes.push_back(8'hFF);
        add_text("\n\nQ");
        send_table();
    endtask

    task automatic test_folded_search();
        load_config(MODE_FOLDED, 6'd3, REPORT_LIMIT_RST, text_of("a_B"));
        add_text("A/b\nb\na b");
        send_table();
    endtask

    task automatic test_exact_find();
        load_config(MODE_EXACT, 6'd2, REPORT_LIMIT_RST, text_of("Ab"));
        add_text("Ab\nAb\nA");
        send_table();
        load_config(MODE_EXACT, 6'd0, REPORT_LIMIT_RST, text_of("Ab"));
        add_text("Ab");
        send_table();
    endtask

    task automatic test_zero_limit();
        load_config(MODE_FOLDED, 6'd0, 10'd0, '0);
        add_text("\n\nx");
        send_table();
    endtask

    task automatic test_table_full();
        int unsigned k;
        calm = 1'b0;
        load_config(MODE_FOLDED, 6'd0, REPORT_LIMIT_RST, '1);
        for (k = 0; k < LINE_MAX_DEF + 3; k++) begin
            if (k == 300) begin
                wait_results();
            end
            send_byte(CH_NL, 1'b0);
        end
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte(CH_NL, 1'b1);
        passes_done++;
        settle_idle();
    endtask

    task automatic test_long_lines();
        logic [TEXT_W-1:0] text;
        int unsigned       k;
        for (k = 0; k < FILTER_CHARS; k++) begin
            text[8*k +: 8] = letter();
        end
        load_config(MODE_EXACT, 6'd32, REPORT_LIMIT_RST, text);
        for (k = 0; k < FILTER_CHARS; k++) table_bytes.push_back(text[8*k +: 8]);
        table_bytes.push_back(CH_NL);
        for (k = 0; k < FILTER_CHARS + 40; k++) begin
            table_bytes.push_back((k < FILTER_CHARS) ? text[8*k +: 8] : letter());
        end
        table_bytes.push_back(CH_NL);
        for (k = 0; k < FILTER_CHARS - 1; k++) table_bytes.push_back(text[8*k +: 8]);
        send_table();
        load_config(MODE_FOLDED, 6'd63, 10'd1023, text);
        for (k = 1; k < FILTER_CHARS; k++) table_bytes.push_back(respell(text[8*k +: 8]));
        table_bytes.push_back(CH_NL);
        table_bytes.push_back("q");
        for (k = 0; k < FILTER_CHARS; k++) table_bytes.push_back(respell(text[8*k +: 8]));
        table_bytes.push_back("q");
        send_table();
    endtask

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 9))
            0: return 10'd0;
            1: return 10'd1;
            2: return LIMIT_W'($urandom_range(2, 3));
            3: return 10'd511;
            4: return 10'd1023;
            5: return LIMIT_W'($urandom_range(0, 1023));
            default: return REPORT_LIMIT_RST;
        endcase
    endfunction

    function automatic void add_line(int unsigned span);
        int unsigned roll;
        int unsigned k;
        int unsigned n;
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            n = $urandom_range(0, 3);
            repeat (n) table_bytes.push_back(letter());
            for (k = 0; k < span; k++) table_bytes.push_back(respell(filter_at(k)));
            n = $urandom_range(0, 3);
            repeat (n) table_bytes.push_back(letter());
        end else if (roll < 55) begin
            for (k = 0; k < span; k++) table_bytes.push_back(filter_at(k));
        end else if (roll < 65) begin
            // empty line
        end else if (roll < 70) begin
            n = $urandom_range(40, 80);
            for (k = 0; k < n; k++) table_bytes.push_back((k < span) ? filter_at(k) : letter());
        end else if (roll < 85) begin
            for (k = 0; k + 1 < span; k++) table_bytes.push_back(filter_at(k));
            if ($urandom_range(0, 1)) table_bytes.push_back(letter());
        end else begin
            n = $urandom_range(0, 8);
            repeat (n) table_bytes.push_back(8'($urandom_range(0, 255)));
        end
        table_bytes.push_back(CH_NL);
    endfunction

    task automatic random_pass();
        logic [TEXT_W-1:0]  text;
        logic [LEN_W-1:0]   flen;
        logic               mode;
        int unsigned        plen;
        int unsigned        roll;
        int unsigned        lines;
        int unsigned        k;
        calm = ($urandom_range(0, 4) == 0);
        mode = ($urandom_range(0, 3) == 0) ? MODE_EXACT : MODE_FOLDED;
        roll = $urandom_range(0, 9);
        plen = (roll == 0) ? 0 : (roll < 8) ? $urandom_range(1, 5) : $urandom_range(6, 32);
        for (k = 0; k < FILTER_CHARS; k++) begin
            text[8*k +: 8] = (k < plen) ? letter() : 8'($urandom_range(0, 255));
        end
        if (plen < FILTER_CHARS && $urandom_range(0, 1)) begin
            text[8*plen +: 8] = 8'h00;
        end
        flen = ($urandom_range(0, 9) < 7) ? LEN_W'(plen) : LEN_W'($urandom_range(0, 63));
        load_config(mode, flen, pick_limit(), text);
        lines = ($urandom_range(0, 14) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        repeat (lines) add_line(filter_span());
        if ($urandom_range(0, 1) && table_bytes.size() > 1) begin
            void'(table_bytes.pop_back());
        end
        send_table();
    endtask

    task automatic test_random_passes();
        int unsigned start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            random_pass();
        end
        calm = 1'b0;
    endtask

    initial begin
        sh_mode  = MODE_FOLDED;
        sh_flen  = '0;
        sh_limit = REPORT_LIMIT_RST;
        sh_text  = '0;
        clear_pass();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_folded_search();
        test_exact_find();
        test_zero_limit();
        test_table_full();
        test_long_lines();
        test_random_passes();

        settle_idle();
        $display("Sent %0d table bytes in %0d passes (%0d exact-mode), checked %0d results",
                 items_sent, passes_done, exact_passes, results_seen);
        $display("Covered empty and full tables, report limits 0 to 1023, filters up to 32 chars");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
